// File: hw/rtl/sacl_pkg.sv
// ----------------------------------------------------------------------------
// sacl_pkg
// shared codes, widths and types of the set-associative lru cache simulator
// ----------------------------------------------------------------------------
package sacl_pkg;

  localparam int ADDR_PORT_W = 64;
  localparam int TOTAL_W     = 32;
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 6;

  typedef logic [1:0] kind_t;
  typedef logic [1:0] outcome_t;
  typedef logic [CFG_INDEX_W-1:0] cfg_index_t;

  // access kinds
  localparam kind_t KIND_LOAD   = 2'd0;
  localparam kind_t KIND_STORE  = 2'd1;
  localparam kind_t KIND_MODIFY = 2'd2;
  localparam kind_t KIND_IFETCH = 2'd3;

  // lookup outcomes
  localparam outcome_t OUTCOME_HIT   = 2'd0;
  localparam outcome_t OUTCOME_FILL  = 2'd1;
  localparam outcome_t OUTCOME_EVICT = 2'd2;

  // configuration register indexes
  localparam cfg_index_t CFG_INDEX_BITS  = 2'd0;
  localparam cfg_index_t CFG_OFFSET_BITS = 2'd1;
  localparam cfg_index_t CFG_WAYS_IN_USE = 2'd2;

  typedef struct packed {
    logic [2:0] index_bits;
    logic [5:0] offset_bits;
    logic [3:0] ways_in_use;
  } cfg_t;

endpackage

// File: hw/rtl/sacl_ram.sv
// ----------------------------------------------------------------------------
// sacl_ram
// generic simple dual-port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module sacl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WIDTH-1:0]  wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: hw/rtl/sacl_split.sv
// ----------------------------------------------------------------------------
// sacl_split
// splits a byte address into set index and tag
// ----------------------------------------------------------------------------
module sacl_split #(
  parameter int MAX_SETS   = 64,
  parameter int ADDR_WIDTH = 64,
  parameter int SET_W      = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1
) (
  input  logic [sacl_pkg::ADDR_PORT_W-1:0] address,
  input  sacl_pkg::cfg_t                   cfg,
  output logic [SET_W-1:0]                 set_idx,
  output logic [ADDR_WIDTH-1:0]            tag
);

  import sacl_pkg::*;

  function automatic int floor_log2(input int n);
    int r;
    r = 0;
    while ((2 << r) <= n) r++;
    return r;
  endfunction

  localparam int S_MAX = floor_log2(MAX_SETS);

  logic [ADDR_WIDTH-1:0] addr;
  logic [ADDR_WIDTH-1:0] setpart;
  logic [ADDR_WIDTH-1:0] mask;
  logic [2:0]            s_eff;
  logic [6:0]            tag_shift;

  always_comb begin
    addr = address[ADDR_WIDTH-1:0];
    // index width limited to what the set count holds
    if (32'(cfg.index_bits) > S_MAX) begin
      s_eff = 3'(S_MAX);
    end else begin
      s_eff = cfg.index_bits;
    end
    setpart   = addr >> cfg.offset_bits;
    mask      = (ADDR_WIDTH'(1) << s_eff) - ADDR_WIDTH'(1);
    set_idx   = SET_W'(setpart & mask);
    // a shift past the address gives a zero tag
    tag_shift = 7'(cfg.offset_bits) + 7'(s_eff);
    tag       = addr >> tag_shift;
  end

endmodule

// File: hw/rtl/sacl_way_update.sv
// ----------------------------------------------------------------------------
// sacl_way_update
// tag compare, victim choice and lru age update of one set row
// ----------------------------------------------------------------------------
module sacl_way_update #(
  parameter int MAX_WAYS   = 8,
  parameter int ADDR_WIDTH = 64,
  parameter int AGE_W      = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1,
  parameter int ROW_W      = MAX_WAYS * (1 + AGE_W + ADDR_WIDTH)
) (
  input  logic [ROW_W-1:0]      row_in,
  input  logic                  row_live,
  input  logic [ADDR_WIDTH-1:0] tag,
  input  sacl_pkg::cfg_t        cfg,
  output logic [ROW_W-1:0]      row_out,
  output sacl_pkg::outcome_t    outcome
);

  import sacl_pkg::*;

  localparam int WAY_W  = 1 + AGE_W + ADDR_WIDTH;
  localparam int WIDX_W = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam logic [AGE_W-1:0] AGE_MAX = AGE_W'(MAX_WAYS - 1);

  logic [MAX_WAYS-1:0]   v;
  logic [MAX_WAYS-1:0]   in_use;
  logic [MAX_WAYS-1:0]   stop;
  logic [AGE_W-1:0]      age [MAX_WAYS];
  logic [AGE_W-1:0]      age_next [MAX_WAYS];
  logic [ADDR_WIDTH-1:0] tg [MAX_WAYS];
  logic [5:0]            ways_eff;
  logic [WIDX_W-1:0]     first_way;
  logic [WIDX_W-1:0]     victim;
  logic [WIDX_W-1:0]     w;
  logic                  found;
  logic                  fill;
  logic [AGE_W-1:0]      old_age;

  always_comb begin
    // ways in use, clamped to 1..MAX_WAYS
    ways_eff = {2'b00, cfg.ways_in_use};
    if (ways_eff == 6'd0) begin
      ways_eff = 6'd1;
    end
    if (ways_eff > 6'(MAX_WAYS)) begin
      ways_eff = 6'(MAX_WAYS);
    end

    for (int k = 0; k < MAX_WAYS; k++) begin
      v[k]      = row_live & row_in[k*WAY_W + WAY_W - 1];
      age[k]    = row_in[k*WAY_W + ADDR_WIDTH +: AGE_W];
      tg[k]     = row_in[k*WAY_W +: ADDR_WIDTH];
      in_use[k] = 6'(k) < ways_eff;
      stop[k]   = in_use[k] & (~v[k] | (tg[k] == tag));
    end

    // first empty or matching way
    first_way = '0;
    for (int k = MAX_WAYS - 1; k >= 0; k--) begin
      if (stop[k]) begin
        first_way = WIDX_W'(k);
      end
    end

    // oldest way, highest way on a tie
    victim = '0;
    for (int k = 0; k < MAX_WAYS; k++) begin
      if (in_use[k] && (age[k] >= age[victim])) begin
        victim = WIDX_W'(k);
      end
    end

    found   = |stop;
    fill    = found && !v[first_way];
    w       = found ? first_way : victim;
    old_age = age[w];

    priority if (!found) begin
      outcome = OUTCOME_EVICT;
    end else if (fill) begin
      outcome = OUTCOME_FILL;
    end else begin
      outcome = OUTCOME_HIT;
    end

    for (int k = 0; k < MAX_WAYS; k++) begin
      age_next[k] = age[k];
      if (in_use[k] && v[k] && (fill || (age[k] < old_age)) && (age[k] < AGE_MAX)) begin
        age_next[k] = age[k] + AGE_W'(1);
      end
      if (WIDX_W'(k) == w) begin
        row_out[k*WAY_W +: WAY_W] = {1'b1, {AGE_W{1'b0}}, tag};
      end else begin
        row_out[k*WAY_W +: WAY_W] = {v[k], age_next[k], tg[k]};
      end
    end
  end

endmodule

// File: hw/rtl/set_assoc_cache_lru_sim_top.sv
// ----------------------------------------------------------------------------
// set_assoc_cache_lru_sim_top
// set-associative cache hit/miss simulator with lru replacement
// ----------------------------------------------------------------------------
// an access is taken at a rising edge with start high and busy low. a load,
// store or modify is a read-modify-write: the set row is read from the line
// ram at acceptance and compared, aged and written back while busy is high,
// so busy is high in the cycle after acceptance and no new access is
// taken until it falls. the result is shown on the output ports with done
// high for exactly one cycle, the cycle after busy; the receiver cannot
// hold it off and must take it then. an instruction fetch is taken without
// raising busy and gives no result. the running totals saturate at all ones.
// after reset the lines read as empty at once through one valid flop per set
// row, so no clearing pass is needed. configuration must be written by the
// user only while no access is in flight; the block itself does not enforce it.
// ----------------------------------------------------------------------------
module set_assoc_cache_lru_sim_top #(
  parameter int MAX_SETS   = 64,
  parameter int MAX_WAYS   = 8,
  parameter int ADDR_WIDTH = 64
) (
  input  logic                             clk,
  input  logic                             rst,
  // access channel
  input  logic                             start,
  output logic                             busy,
  input  sacl_pkg::kind_t                  kind,
  input  logic [sacl_pkg::ADDR_PORT_W-1:0] address,
  // configuration write port
  input  logic                             cfg_write,
  input  sacl_pkg::cfg_index_t             cfg_index,
  input  logic [sacl_pkg::CFG_DATA_W-1:0]  cfg_data,
  // result channel
  output logic                             done,
  output sacl_pkg::outcome_t               outcome,
  output logic                             modify_hit,
  output logic [sacl_pkg::TOTAL_W-1:0]     hit_total,
  output logic [sacl_pkg::TOTAL_W-1:0]     miss_total,
  output logic [sacl_pkg::TOTAL_W-1:0]     eviction_total
);

  import sacl_pkg::*;

  localparam int SET_W = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
  localparam int AGE_W = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int ROW_W = MAX_WAYS * (1 + AGE_W + ADDR_WIDTH);

  // configuration registers
  cfg_t cfg;

  // access in flight
  logic                  accept;
  logic [SET_W-1:0]      set_in;
  logic [ADDR_WIDTH-1:0] tag_in;
  logic [SET_W-1:0]      set_q;
  logic [ADDR_WIDTH-1:0] tag_q;
  logic                  modify_q;

  // line storage: one ram row per set, one valid flop per row
  logic [MAX_SETS-1:0]   row_valid;
  logic [ROW_W-1:0]      row_rd;
  logic [ROW_W-1:0]      row_wr;
  outcome_t              lookup_outcome;

  // running totals
  logic [TOTAL_W-1:0]    hits_seen;
  logic [TOTAL_W-1:0]    misses_seen;
  logic [TOTAL_W-1:0]    evictions_seen;
  logic [TOTAL_W-1:0]    hits_seen_next;
  logic [TOTAL_W-1:0]    misses_seen_next;
  logic [TOTAL_W-1:0]    evictions_seen_next;
  logic [1:0]            hit_inc;
  logic [TOTAL_W:0]      hit_sum;
  logic [TOTAL_W:0]      miss_sum;
  logic [TOTAL_W:0]      evict_sum;

  // instruction fetches are taken but start no work
  assign accept = start && !busy && (kind != KIND_IFETCH);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.index_bits  <= 3'd0;
      cfg.offset_bits <= 6'd0;
      cfg.ways_in_use <= 4'd1;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_INDEX_BITS:  cfg.index_bits  <= cfg_data[2:0];
        CFG_OFFSET_BITS: cfg.offset_bits <= cfg_data[5:0];
        CFG_WAYS_IN_USE: cfg.ways_in_use <= cfg_data[3:0];
        default: begin
          // index beyond the register list, write dropped
        end
      endcase
    end
  end

  sacl_split #(
    .MAX_SETS   (MAX_SETS),
    .ADDR_WIDTH (ADDR_WIDTH),
    .SET_W      (SET_W)
  ) u_split (
    .address (address),
    .cfg     (cfg),
    .set_idx (set_in),
    .tag     (tag_in)
  );

  // read the set row on acceptance, write it back in the following cycle; busy
  // blocks the next read until the write has landed
  sacl_ram #(
    .WIDTH  (ROW_W),
    .DEPTH  (MAX_SETS),
    .ADDR_W (SET_W)
  ) u_lines (
    .clk     (clk),
    .wr_en   (busy),
    .wr_addr (set_q),
    .wr_data (row_wr),
    .rd_en   (accept),
    .rd_addr (set_in),
    .rd_data (row_rd)
  );

  sacl_way_update #(
    .MAX_WAYS   (MAX_WAYS),
    .ADDR_WIDTH (ADDR_WIDTH),
    .AGE_W      (AGE_W),
    .ROW_W      (ROW_W)
  ) u_way_update (
    .row_in   (row_rd),
    .row_live (row_valid[set_q]),
    .tag      (tag_q),
    .cfg      (cfg),
    .row_out  (row_wr),
    .outcome  (lookup_outcome)
  );

  // saturating totals, a modify hit may add two
  always_comb begin
    hit_inc   = {1'b0, lookup_outcome == OUTCOME_HIT} + {1'b0, modify_q};
    hit_sum   = {1'b0, hits_seen} + (TOTAL_W + 1)'(hit_inc);
    miss_sum  = {1'b0, misses_seen} + (TOTAL_W + 1)'(lookup_outcome != OUTCOME_HIT);
    evict_sum = {1'b0, evictions_seen} + (TOTAL_W + 1)'(lookup_outcome == OUTCOME_EVICT);
    hits_seen_next      = hit_sum[TOTAL_W]   ? '1 : hit_sum[TOTAL_W-1:0];
    misses_seen_next    = miss_sum[TOTAL_W]  ? '1 : miss_sum[TOTAL_W-1:0];
    evictions_seen_next = evict_sum[TOTAL_W] ? '1 : evict_sum[TOTAL_W-1:0];
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      busy           <= 1'b0;
      done           <= 1'b0;
      row_valid      <= '0;
      hits_seen      <= '0;
      misses_seen    <= '0;
      evictions_seen <= '0;
    end else begin
      busy <= accept;
      done <= busy;
      if (busy) begin
        row_valid[set_q] <= 1'b1;
        hits_seen        <= hits_seen_next;
        misses_seen      <= misses_seen_next;
        evictions_seen   <= evictions_seen_next;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      set_q    <= set_in;
      tag_q    <= tag_in;
      modify_q <= (kind == KIND_MODIFY);
    end
    if (busy) begin
      outcome    <= lookup_outcome;
      modify_hit <= modify_q;
    end
  end

  assign hit_total      = hits_seen;
  assign miss_total     = misses_seen;
  assign eviction_total = evictions_seen;

  // busy covers the read-modify-write of one item and is never high back to back
  a_busy_single: assert property (@(posedge clk) disable iff (rst) busy |=> !busy)
    else $error("busy held for more than one cycle");

  a_done_follows_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("result strobe without an item in flight");

  a_miss_counted: assert property (@(posedge clk) disable iff (rst)
    (done && (outcome != OUTCOME_HIT)) |-> (miss_total != '0))
    else $error("miss reported but miss total is zero");

  a_evict_counted: assert property (@(posedge clk) disable iff (rst)
    (done && (outcome == OUTCOME_EVICT)) |-> (eviction_total != '0))
    else $error("eviction reported but eviction total is zero");

  a_hits_monotonic: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> (hits_seen >= $past(hits_seen)))
    else $error("hit total went down");

endmodule

// File: dv/tb_set_assoc_cache_lru_sim_top.sv
// ----------------------------------------------------------------------------
// tb_set_assoc_cache_lru_sim_top
// self-checking bench for the set-associative lru cache hit/miss simulator
// ----------------------------------------------------------------------------
// drives trace accesses through the start/busy port and programs the three
// cache registers between phases, while the cache is idle. a behavioural lru
// cache in a scoreboard class predicts the outcome and the running totals of
// every lookup, and each done strobe is compared field by field with the
// oldest prediction. a short directed part is followed by random phases
// whose addresses are built from a small pool of tags and hot sets so that
// hits, fills and evictions all occur under many register settings.
// ----------------------------------------------------------------------------
module tb_set_assoc_cache_lru_sim_top;

  import sacl_pkg::*;

  localparam int unsigned CACHE_SETS      = 64;
  localparam int unsigned CACHE_WAYS      = 8;
  localparam int unsigned CACHE_LINES     = CACHE_SETS * CACHE_WAYS;
  localparam int unsigned MAX_SET_LOG     = 6;
  // idle cycles that cover anything still in flight after a drain
  localparam int unsigned SETTLE_CYCLES   = 4;
  localparam int unsigned QUIET_LIMIT     = 2000;
  localparam int unsigned REPORT_LIMIT    = 10;
  localparam int unsigned RANDOM_PHASES   = 10;
  localparam int unsigned ITEMS_PER_PHASE = 103;

  // what one lookup should produce on the result ports
  typedef struct {
    outcome_t    outcome;
    logic        modify_hit;
    logic [31:0] hit_total;
    logic [31:0] miss_total;
    logic [31:0] eviction_total;
  } lookup_t;

  // --------------------------------------------------------------------------
  // lru cache predictor and store of pending lookups
  // --------------------------------------------------------------------------
  class lru_cache_checker;
    bit          line_valid [CACHE_LINES];
    logic [63:0] line_tag   [CACHE_LINES];
    int unsigned line_age   [CACHE_LINES];
    logic [2:0]  index_bits;
    logic [5:0]  offset_bits;
    logic [3:0]  ways_in_use;
    logic [31:0] hit_count;
    logic [31:0] miss_count;
    logic [31:0] evict_count;
    lookup_t     pending_lookups [$];
    int unsigned mismatches;
    int unsigned checked;
    int unsigned seen_hits;
    int unsigned seen_fills;
    int unsigned seen_evicts;
    int unsigned seen_modifies;

    function new();
      index_bits  = 3'd0;
      offset_bits = 6'd0;
      ways_in_use = 4'd1;
      foreach (line_valid[i]) begin
        line_valid[i] = 1'b0;
        line_tag[i]   = 64'd0;
        line_age[i]   = 0;
      end
      hit_count     = 32'd0;
      miss_count    = 32'd0;
      evict_count   = 32'd0;
      mismatches    = 0;
      checked       = 0;
      seen_hits     = 0;
      seen_fills    = 0;
      seen_evicts   = 0;
      seen_modifies = 0;
    endfunction

    function void write_register(cfg_index_t idx, logic [5:0] data);
      case (idx)
        CFG_INDEX_BITS:  index_bits  = data[2:0];
        CFG_OFFSET_BITS: offset_bits = data;
        CFG_WAYS_IN_USE: ways_in_use = data[3:0];
        default: ;
      endcase
    endfunction

    function int unsigned pending();
      return pending_lookups.size();
    endfunction

    function logic [31:0] bump(logic [31:0] v);
      return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
    endfunction

    // index width clipped so that the sets fit
    function int unsigned set_log();
      int unsigned s;
      s = 0;
      while (s < index_bits && (2 << s) <= CACHE_SETS) s++;
      return s;
    endfunction

    function int unsigned way_span();
      if (ways_in_use == 4'd0) return 1;
      if (ways_in_use > CACHE_WAYS) return CACHE_WAYS;
      return 32'(ways_in_use);
    endfunction

    // touched way becomes newest, younger valid lines age by one
    function void promote(int unsigned base, int unsigned ways, int unsigned w,
                          int unsigned old_age);
      for (int unsigned k = 0; k < ways; k++) begin
        if (k != w && line_valid[base+k] && line_age[base+k] < old_age &&
            line_age[base+k] < CACHE_WAYS - 1)
          line_age[base+k]++;
      end
      line_age[base+w] = 0;
    endfunction

    function void note_access(kind_t acc_kind, logic [63:0] addr);
      int unsigned s;
      int unsigned b;
      int unsigned ways;
      int unsigned set_no;
      int unsigned base;
      int unsigned victim;
      logic [63:0] tag;
      lookup_t     exp;
      bit          found;
      if (acc_kind == KIND_IFETCH) return;
      s      = set_log();
      b      = 32'(offset_bits);
      ways   = way_span();
      set_no = 32'((addr >> b) & ((64'd1 << s) - 64'd1));
      tag    = (b + s < 64) ? (addr >> (b + s)) : 64'd0;
      base   = set_no * CACHE_WAYS;
      found  = 1'b0;
      exp.outcome = OUTCOME_EVICT;
      for (int unsigned k = 0; k < ways && !found; k++) begin
        if (!line_valid[base+k]) begin
          line_valid[base+k] = 1'b1;
          line_tag[base+k]   = tag;
          promote(base, ways, k, 32'hFFFF_FFFF);
          miss_count  = bump(miss_count);
          exp.outcome = OUTCOME_FILL;
          found       = 1'b1;
        end else if (line_tag[base+k] == tag) begin
          promote(base, ways, k, line_age[base+k]);
          hit_count   = bump(hit_count);
          exp.outcome = OUTCOME_HIT;
          found       = 1'b1;
        end
      end
      if (!found) begin
        // oldest line goes, highest way on a tie
        victim = 0;
        for (int unsigned k = 0; k < ways; k++)
          if (line_age[base+k] >= line_age[base+victim]) victim = k;
        line_tag[base+victim] = tag;
        promote(base, ways, victim, line_age[base+victim]);
        miss_count  = bump(miss_count);
        evict_count = bump(evict_count);
      end
      if (acc_kind == KIND_MODIFY) hit_count = bump(hit_count);
      exp.modify_hit     = (acc_kind == KIND_MODIFY);
      exp.hit_total      = hit_count;
      exp.miss_total     = miss_count;
      exp.eviction_total = evict_count;
      pending_lookups.push_back(exp);
    endfunction

    function void check_result(outcome_t o, logic mh, logic [31:0] h,
                               logic [31:0] m, logic [31:0] e);
      lookup_t exp;
      if (pending_lookups.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("result with nothing pending: outcome %0d modify %0d h/m/e %0d/%0d/%0d",
                   o, mh, h, m, e);
        return;
      end
      exp = pending_lookups.pop_front();
      checked++;
      case (exp.outcome)
        OUTCOME_HIT:  seen_hits++;
        OUTCOME_FILL: seen_fills++;
        default:      seen_evicts++;
      endcase
      if (exp.modify_hit) seen_modifies++;
      if (o !== exp.outcome || mh !== exp.modify_hit || h !== exp.hit_total ||
          m !== exp.miss_total || e !== exp.eviction_total) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT) begin
          $display("lookup %0d mismatch at %0t", checked, $realtime);
          $display("  expected outcome %0d modify %0d h/m/e %0d/%0d/%0d",
                   exp.outcome, exp.modify_hit, exp.hit_total, exp.miss_total,
                   exp.eviction_total);
          $display("  actual   outcome %0d modify %0d h/m/e %0d/%0d/%0d",
                   o, mh, h, m, e);
        end
      end
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // clock, reset and block ports
  // --------------------------------------------------------------------------
  logic                    clk = 1'b0;
  logic                    rst;
  logic                    start;
  logic                    busy;
  kind_t                   kind;
  logic [ADDR_PORT_W-1:0]  address;
  logic                    cfg_write;
  cfg_index_t              cfg_index;
  logic [CFG_DATA_W-1:0]   cfg_data;
  logic                    done;
  outcome_t                outcome;
  logic                    modify_hit;
  logic [TOTAL_W-1:0]      hit_total;
  logic [TOTAL_W-1:0]      miss_total;
  logic [TOTAL_W-1:0]      eviction_total;

  lru_cache_checker lookups = new();

  // settings as last programmed, clipped the way the cache clips them,
  // used only to shape addresses that land in busy sets
  int unsigned cur_set_log;
  int unsigned cur_offset;
  int unsigned cur_ways;
  int unsigned settings_count;
  int unsigned fetch_count;
  int unsigned quiet_cycles;
  bit          gaps_on;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  set_assoc_cache_lru_sim_top i_dut (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .busy           (busy),
    .kind           (kind),
    .address        (address),
    .cfg_write      (cfg_write),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .done           (done),
    .outcome        (outcome),
    .modify_hit     (modify_hit),
    .hit_total      (hit_total),
    .miss_total     (miss_total),
    .eviction_total (eviction_total)
  );

  // --------------------------------------------------------------------------
  // monitor: everything sampled at the rising edge, before the block updates
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst) begin
      // results first: a result never belongs to an item taken at this edge
      if (done)
        lookups.check_result(outcome, modify_hit, hit_total, miss_total,
                             eviction_total);
      if (start && !busy) lookups.note_access(kind, address);
      if (cfg_write) lookups.write_register(cfg_index, cfg_data);
    end
  end

  // watchdog: ends the run when nothing moves for too long
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles + 1 >= QUIET_LIMIT) begin
        $display("no progress for %0d cycles, %0d lookups pending",
                 QUIET_LIMIT, lookups.pending());
        $display("FAILURE");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // stimulus helpers
  // --------------------------------------------------------------------------

  // mostly back to back, sometimes a short gap, now and then a long one
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 25);
  endfunction

  // start stays high into the next item unless a gap lowers it
  task automatic send_access(kind_t k, logic [63:0] a);
    start   <= 1'b1;
    kind    <= k;
    address <= a;
    do @(posedge clk); while (busy);
  endtask

  task automatic hold_start();
    if (start) start <= 1'b0;
  endtask

  task automatic issue(kind_t k, logic [63:0] a);
    int unsigned gap;
    send_access(k, a);
    if (k == KIND_IFETCH) fetch_count++;
    gap = gaps_on ? pick_gap() : 0;
    if (gap > 0) begin
      hold_start();
      repeat (gap) @(posedge clk);
    end
  endtask

  // pending count read at the falling edge, clear of the monitor's updates
  task automatic drain();
    hold_start();
    @(negedge clk);
    while (lookups.pending() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // all three registers in consecutive cycles, junk in the unused data bits
  task automatic program_cache(int unsigned s, int unsigned b, int unsigned e);
    logic [5:0] word;
    drain();
    word      = 6'($urandom);
    word[2:0] = s[2:0];
    cfg_write <= 1'b1;
    cfg_index <= CFG_INDEX_BITS;
    cfg_data  <= word;
    @(posedge clk);
    cfg_index <= CFG_OFFSET_BITS;
    cfg_data  <= b[5:0];
    @(posedge clk);
    word      = 6'($urandom);
    word[3:0] = e[3:0];
    cfg_index <= CFG_WAYS_IN_USE;
    cfg_data  <= word;
    @(posedge clk);
    cfg_write <= 1'b0;
    cur_set_log = (s[2:0] > MAX_SET_LOG) ? MAX_SET_LOG : 32'(s[2:0]);
    cur_offset  = 32'(b[5:0]);
    cur_ways    = (e[3:0] == 0) ? 1 : (e[3:0] > CACHE_WAYS) ? CACHE_WAYS : 32'(e[3:0]);
    settings_count++;
  endtask

  // tag, set and a random offset packed for the current geometry
  function automatic logic [63:0] shaped_address(logic [63:0] tag,
                                                 logic [63:0] set_no);
    logic [63:0] off;
    logic [63:0] tag_part;
    off      = {$urandom, $urandom} & ((64'd1 << cur_offset) - 64'd1);
    tag_part = (cur_offset + cur_set_log < 64) ? tag << (cur_offset + cur_set_log)
                                               : 64'd0;
    return tag_part | (set_no << cur_offset) | off;
  endfunction

  // a phase of random traffic: a small tag pool on a few hot sets keeps the
  // sets under pressure, with some fully random addresses as noise
  task automatic random_phase(int unsigned n_items);
    logic [63:0] tag_pool [$];
    logic [63:0] a;
    int unsigned set_count;
    int unsigned hot_sets;
    int unsigned sent;
    int unsigned pool_size;
    bit          mid_drain;
    bit          drained;
    kind_t       k;
    set_count = 1 << cur_set_log;
    hot_sets  = $urandom_range(1, (set_count < 4) ? set_count : 4);
    pool_size = cur_ways + $urandom_range(1, 4);
    for (int unsigned i = 0; i < pool_size; i++)
      tag_pool.push_back($urandom_range(0, 1) ? {$urandom, $urandom}
                                              : 64'($urandom_range(0, 15)));
    gaps_on   = ($urandom_range(0, 3) != 0);
    mid_drain = ($urandom_range(0, 2) == 0);
    drained   = 1'b0;
    sent      = 0;
    while (sent < n_items) begin
      k = ($urandom_range(0, 99) < 8) ? KIND_IFETCH : kind_t'($urandom_range(0, 2));
      if ($urandom_range(0, 99) < 15)
        a = {$urandom, $urandom};
      else
        a = shaped_address(tag_pool[$urandom_range(0, pool_size - 1)],
                           64'(($urandom_range(0, 9) == 0)
                               ? $urandom_range(0, set_count - 1)
                               : $urandom_range(0, hot_sets - 1)));
      issue(k, a);
      sent++;
      // in a mid-drain phase the sender waits once, halfway, for every outstanding result
      if (mid_drain && !drained && sent >= n_items / 2) begin
        drain();
        drained = 1'b1;
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // main sequence
  // --------------------------------------------------------------------------
  initial begin
    rst       <= 1'b1;
    start     <= 1'b0;
    kind      <= KIND_LOAD;
    address   <= '0;
    cfg_write <= 1'b0;
    cfg_index <= CFG_INDEX_BITS;
    cfg_data  <= '0;
    cur_set_log    = 0;
    cur_offset     = 0;
    cur_ways       = 1;
    settings_count = 0;
    fetch_count    = 0;
    gaps_on        = 1'b1;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // reset geometry: one set, one way; fill, hit, evict, modify hit,
    // and a fetch that must leave no trace
    issue(KIND_LOAD,   64'd0);
    issue(KIND_LOAD,   64'd0);
    issue(KIND_STORE,  64'hFFFF_FFFF_FFFF_FFFF);
    issue(KIND_MODIFY, 64'hFFFF_FFFF_FFFF_FFFF);
    issue(KIND_IFETCH, 64'd0);
    issue(KIND_LOAD,   64'd0);

    // index too wide, offset at its top, zero ways: tag shifts out to zero
    // and the set comes from the top address bit alone
    program_cache(7, 63, 0);
    issue(KIND_LOAD,   64'h8000_0000_0000_0000);
    issue(KIND_STORE,  64'd0);
    issue(KIND_MODIFY, 64'h7FFF_FFFF_FFFF_FFFF);

    // ways above the maximum: fill all eight, then the oldest is evicted
    program_cache(0, 0, 15);
    for (int unsigned t = 1; t <= CACHE_WAYS; t++) issue(KIND_LOAD, 64'(t));
    issue(KIND_LOAD,   64'd9);
    issue(KIND_MODIFY, 64'd2);

    // shrink the set so a tag held in an upper way is refetched below it,
    // then widen again: the same tag sits twice and the lower way must hit
    program_cache(0, 0, 2);
    issue(KIND_LOAD, 64'd3);
    issue(KIND_IFETCH, 64'hFFFF_FFFF_FFFF_FFFF);
    program_cache(0, 0, 8);
    issue(KIND_LOAD, 64'd3);

    // random phases: a few extreme geometries, then random ones
    for (int unsigned p = 0; p < RANDOM_PHASES; p++) begin
      case (p)
        0:       program_cache(6, 0, 8);
        1:       program_cache(0, 63, 1);
        2:       program_cache(2, 32, 0);
        3:       program_cache(6, 58, 8);
        4:       program_cache(7, 5, 15);
        default: program_cache($urandom_range(0, 7),
                               $urandom_range(0, 1) ? $urandom_range(0, 12)
                                                    : $urandom_range(0, 63),
                               $urandom_range(0, 15));
      endcase
      random_phase(ITEMS_PER_PHASE);
    end

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("checked %0d lookups: %0d hits, %0d fills, %0d evictions, %0d modifies",
             lookups.checked, lookups.seen_hits, lookups.seen_fills,
             lookups.seen_evicts, lookups.seen_modifies);
    $display("%0d cache geometries programmed, %0d ignored fetches sent",
             settings_count, fetch_count);
    if (lookups.mismatches == 0 && lookups.pending() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("%0d mismatches, %0d lookups left pending",
               lookups.mismatches, lookups.pending());
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// File: filelist.f
hw/rtl/sacl_pkg.sv
hw/rtl/sacl_ram.sv
hw/rtl/sacl_split.sv
hw/rtl/sacl_way_update.sv
hw/rtl/set_assoc_cache_lru_sim_top.sv
dv/tb_set_assoc_cache_lru_sim_top.sv
